// File: rtl/core/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Types, character codes and helpers shared by the integer formatter blocks.
// ----------------------------------------------------------------------------
package itaf_pkg;

	localparam int VALUE_W     = 64;
	localparam int CNT_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int NIB_W       = 4;
	localparam int BIN_NIBS    = VALUE_W / NIB_W;
	localparam int ITER_W      = $clog2(BIN_NIBS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// conversion codes
	typedef enum logic [1:0] {
		CONV_SDEC = 2'd0,
		CONV_UDEC = 2'd1,
		CONV_HEXL = 2'd2,
		CONV_HEXU = 2'd3
	} conv_t;

	// operand size codes
	typedef enum logic [1:0] {
		SIZE_INT   = 2'd0,
		SIZE_CHAR  = 2'd1,
		SIZE_SHORT = 2'd2,
		SIZE_LONG  = 2'd3
	} size_sel_t;

	localparam logic [VALUE_W-1:0] MASK_CHAR  = 64'h0000_0000_0000_00FF;
	localparam logic [VALUE_W-1:0] MASK_SHORT = 64'h0000_0000_0000_FFFF;
	localparam logic [VALUE_W-1:0] MASK_NONE  = 64'hFFFF_FFFF_FFFF_FFFF;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;

	// classified item as it travels from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               is_dec;
		logic               upper;
		logic [CHAR_W-1:0]  pre0;
		logic [CHAR_W-1:0]  pre1;
		logic [1:0]         pre_len;
		logic               zero_pad;
		logic               left;
		logic [CNT_W-1:0]   width;
		logic [CNT_W-1:0]   prec;
	} spec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_PLAN,
		ST_BOUND,
		ST_EMIT
	} back_state_t;

	// one digit (0..15) to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] res;
		if (d < 4'd10) begin
			res = CH_ZERO + {4'b0000, d};
		end else begin
			res = (upper ? CH_A_UP : CH_A_LO) + {4'b0000, d - 4'd10};
		end
		return res;
	endfunction

endpackage

// File: rtl/core/itaf_front.sv
// ----------------------------------------------------------------------------
// itaf_front
// Classifies one input item: size mask, sign handling, prefix selection,
// flag overrides and width/precision saturation.
// ----------------------------------------------------------------------------
module itaf_front #(
	parameter int MAX_FIELD = 63
) (
	input  logic signed [63:0] value,
	input  logic [1:0]         conv,
	input  logic [1:0]         size_sel,
	input  logic               alt_form,
	input  logic               pad_zero,
	input  logic               left_justify,
	input  logic               plus_sign,
	input  logic               space_sign,
	input  logic [5:0]         field_width,
	input  logic [5:0]         min_precision,
	output itaf_pkg::spec_t    spec
);

	localparam logic [itaf_pkg::CNT_W-1:0] FIELD_MAX = itaf_pkg::CNT_W'(MAX_FIELD);

	logic [itaf_pkg::VALUE_W-1:0] raw;
	logic [itaf_pkg::VALUE_W-1:0] mask;
	logic [itaf_pkg::VALUE_W-1:0] masked;
	logic                         is_dec;
	logic                         neg;

	assign raw = value;

	// size mask
	always_comb begin
		case (size_sel)
			itaf_pkg::SIZE_CHAR:  mask = itaf_pkg::MASK_CHAR;
			itaf_pkg::SIZE_SHORT: mask = itaf_pkg::MASK_SHORT;
			default:              mask = itaf_pkg::MASK_NONE;
		endcase
	end

	assign masked = raw & mask;
	assign is_dec = (conv == itaf_pkg::CONV_SDEC) || (conv == itaf_pkg::CONV_UDEC);
	assign neg    = (conv == itaf_pkg::CONV_SDEC) && raw[itaf_pkg::VALUE_W-1];

	// classified item
	always_comb begin
		spec          = '0;
		spec.mag      = neg ? (-raw) : masked;
		spec.is_dec   = is_dec;
		spec.upper    = (conv == itaf_pkg::CONV_HEXU);
		spec.zero_pad = pad_zero & ~left_justify;
		spec.left     = left_justify;
		spec.width    = (field_width > FIELD_MAX) ? FIELD_MAX : field_width;
		spec.prec     = (min_precision > FIELD_MAX) ? FIELD_MAX : min_precision;
		spec.pre0     = itaf_pkg::CH_ZERO;
		spec.pre1     = (conv == itaf_pkg::CONV_HEXU) ? itaf_pkg::CH_X_UP : itaf_pkg::CH_X_LO;
		if (is_dec) begin
			if (neg) begin
				spec.pre0    = itaf_pkg::CH_MINUS;
				spec.pre_len = 2'd1;
			end else if (plus_sign) begin
				spec.pre0    = itaf_pkg::CH_PLUS;
				spec.pre_len = 2'd1;
			end else if (space_sign) begin
				spec.pre0    = itaf_pkg::CH_SPACE;
				spec.pre_len = 2'd1;
			end
		end else if (alt_form && (masked != '0)) begin
			spec.pre_len = 2'd2;
		end
	end

endmodule

// File: rtl/core/itaf_queue.sv
// ----------------------------------------------------------------------------
// itaf_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module itaf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  itaf_pkg::spec_t      wdata,
	input  logic                 pop,
	output itaf_pkg::spec_t      rdata,
	output itaf_pkg::q_status_t  status
);

	itaf_pkg::spec_t                    mem_q [itaf_pkg::QUEUE_DEPTH];
	logic [itaf_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [itaf_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [itaf_pkg::QUEUE_CW-1:0]      cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata        = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == itaf_pkg::QUEUE_CW'(itaf_pkg::QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

endmodule

// File: rtl/core/itaf_back.sv
// ----------------------------------------------------------------------------
// itaf_back
// Converts one classified item to digits (shift-add-3, four bits a cycle for
// decimal, direct nibbles for hex), plans the run layout and emits the run
// one character per cycle, unless stalled, through an output register.
// ----------------------------------------------------------------------------
module itaf_back #(
	parameter int DIGIT_DEPTH = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itaf_pkg::q_status_t  q_status,
	input  itaf_pkg::spec_t      q_rdata,
	output logic                 pop,
	output logic                 char_valid,
	input  logic                 char_stall,
	output logic [7:0]           ch,
	output logic                 last
);

	localparam int DIG_W = DIGIT_DEPTH * itaf_pkg::NIB_W;
	localparam int ND_W  = $clog2(DIGIT_DEPTH + 1);
	localparam int DIX_W = $clog2(DIGIT_DEPTH);
	localparam int CW    = itaf_pkg::CNT_W;

	itaf_pkg::back_state_t                     state_q, state_d;
	itaf_pkg::spec_t                           spec_q;
	logic [DIGIT_DEPTH-1:0][itaf_pkg::NIB_W-1:0] bcd_q, bcd_conv, bcd_load;
	logic [itaf_pkg::VALUE_W-1:0]              bin_q;
	logic [itaf_pkg::ITER_W-1:0]               iter_q;
	logic [ND_W-1:0]                           nd_q, nd_d;
	logic [CW-1:0]                             pad_q, wid_q;
	logic [CW-1:0]                             b1_q, b2_q, b3_q, b4_q, last_idx_q, pos_q;
	logic                                      ovalid_q;
	logic [itaf_pkg::CHAR_W-1:0]               ch_q, ch_d;
	logic                                      olast_q;
	logic                                      emit_load;
	logic                                      conv_done;
	logic [CW-1:0]                             len, lp, p_d, w_d;
	logic [CW-1:0]                             lb, zc, tb, b1_d, b2_d, b3_d, b4_d, tot_d;
	logic [CW-1:0]                             didx_full;
	logic [itaf_pkg::NIB_W-1:0]                dig;

	assign conv_done = (iter_q == {itaf_pkg::ITER_W{1'b1}});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			itaf_pkg::ST_IDLE: begin
				if (!q_status.empty) begin
					state_d = q_rdata.is_dec ? itaf_pkg::ST_CONV : itaf_pkg::ST_COUNT;
				end
			end
			itaf_pkg::ST_CONV: begin
				if (conv_done) begin
					state_d = itaf_pkg::ST_COUNT;
				end
			end
			itaf_pkg::ST_COUNT: state_d = itaf_pkg::ST_PLAN;
			itaf_pkg::ST_PLAN:  state_d = itaf_pkg::ST_BOUND;
			itaf_pkg::ST_BOUND: state_d = itaf_pkg::ST_EMIT;
			itaf_pkg::ST_EMIT: begin
				if (emit_load && (pos_q == last_idx_q)) begin
					state_d = itaf_pkg::ST_IDLE;
				end
			end
			default: state_d = itaf_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			itaf_pkg::ST_IDLE: pop       = ~q_status.empty;
			itaf_pkg::ST_EMIT: emit_load = ~ovalid_q | ~char_stall;
			default: begin
				pop       = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	// shift-add-3 over four input bits
	always_comb begin
		logic [DIG_W-1:0] flat;
		bcd_conv = bcd_q;
		for (int s = 0; s < itaf_pkg::NIB_W; s++) begin
			for (int d = 0; d < DIGIT_DEPTH; d++) begin
				if (bcd_conv[d] >= 4'd5) begin
					bcd_conv[d] = bcd_conv[d] + 4'd3;
				end
			end
			flat     = bcd_conv;
			flat     = {flat[DIG_W-2:0], bin_q[itaf_pkg::VALUE_W-1-s]};
			bcd_conv = flat;
		end
	end

	// hex nibbles load straight into the digit buffer
	always_comb begin
		logic [DIG_W-1:0] flat;
		flat                          = '0;
		flat[itaf_pkg::VALUE_W-1:0]   = q_rdata.mag;
		bcd_load                      = flat;
	end

	// digit count: highest nonzero digit, at least one
	always_comb begin
		nd_d = ND_W'(1);
		for (int d = 0; d < DIGIT_DEPTH; d++) begin
			if (bcd_q[d] != '0) begin
				nd_d = ND_W'(d + 1);
			end
		end
	end

	// precision zeros and width padding
	always_comb begin
		len = CW'(nd_q) + CW'(spec_q.pre_len);
		p_d = (spec_q.prec > len) ? (spec_q.prec - len) : '0;
		lp  = len + p_d;
		w_d = (spec_q.width > lp) ? (spec_q.width - lp) : '0;
	end

	// segment boundaries of the run
	always_comb begin
		lb    = (!spec_q.left && !spec_q.zero_pad) ? wid_q : '0;
		zc    = pad_q + ((!spec_q.left && spec_q.zero_pad) ? wid_q : '0);
		tb    = spec_q.left ? wid_q : '0;
		b1_d  = lb;
		b2_d  = b1_d + CW'(spec_q.pre_len);
		b3_d  = b2_d + zc;
		b4_d  = b3_d + CW'(nd_q);
		tot_d = b4_d + tb;
	end

	// character at the current position
	assign didx_full = b4_q - CW'(1) - pos_q;
	assign dig       = bcd_q[didx_full[DIX_W-1:0]];

	always_comb begin
		if (pos_q < b1_q) begin
			ch_d = itaf_pkg::CH_SPACE;
		end else if (pos_q < b2_q) begin
			ch_d = (pos_q == b1_q) ? spec_q.pre0 : spec_q.pre1;
		end else if (pos_q < b3_q) begin
			ch_d = itaf_pkg::CH_ZERO;
		end else if (pos_q < b4_q) begin
			ch_d = itaf_pkg::digit_char(dig, spec_q.upper);
		end else begin
			ch_d = itaf_pkg::CH_SPACE;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itaf_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				ovalid_q <= 1'b1;
			end else if (!char_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			itaf_pkg::ST_IDLE: begin
				spec_q <= q_rdata;
				bin_q  <= q_rdata.mag;
				iter_q <= '0;
				bcd_q  <= q_rdata.is_dec ? '0 : bcd_load;
			end
			itaf_pkg::ST_CONV: begin
				bcd_q  <= bcd_conv;
				bin_q  <= {bin_q[itaf_pkg::VALUE_W-itaf_pkg::NIB_W-1:0], {itaf_pkg::NIB_W{1'b0}}};
				iter_q <= iter_q + 1'b1;
			end
			itaf_pkg::ST_COUNT: nd_q <= nd_d;
			itaf_pkg::ST_PLAN: begin
				pad_q <= p_d;
				wid_q <= w_d;
			end
			itaf_pkg::ST_BOUND: begin
				b1_q       <= b1_d;
				b2_q       <= b2_d;
				b3_q       <= b3_d;
				b4_q       <= b4_d;
				last_idx_q <= tot_d - CW'(1);
				pos_q      <= '0;
			end
			itaf_pkg::ST_EMIT: begin
				if (emit_load) begin
					pos_q <= pos_q + CW'(1);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
		if (emit_load) begin
			ch_q    <= ch_d;
			olast_q <= (pos_q == last_idx_q);
		end
	end

	assign char_valid = ovalid_q;
	assign ch         = ch_q;
	assign last       = olast_q;

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style %d/%u/%x/%X conversion of one 64-bit value to an ASCII run.
// ----------------------------------------------------------------------------
// Each accepted item yields a run of 1 to 63 characters on ch, with last set
// on the final one. Items are classified as they enter and wait in a
// two-entry queue, so item_stall rises only when both entries are taken.
// The back end handles one item at a time. A decimal item is loaded and
// converted by shift-add-3 at four bits a cycle; a hex item skips that.
// Then come digit count, padding plan and segment bounds, and the N
// characters leave at one a cycle while the character side does not stall.
// N is the run length, max(width, precision, prefix plus digits). A stall on
// the character side holds the output register and pauses the run.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
	parameter int DIGIT_DEPTH = 20,
	parameter int MAX_FIELD   = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [63:0] value,
	input  logic [1:0]         conv,
	input  logic [1:0]         size_sel,
	input  logic               alt_form,
	input  logic               pad_zero,
	input  logic               left_justify,
	input  logic               plus_sign,
	input  logic               space_sign,
	input  logic [5:0]         field_width,
	input  logic [5:0]         min_precision,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [7:0]         ch,
	output logic               last
);

	itaf_pkg::spec_t     spec_in;
	itaf_pkg::spec_t     spec_out;
	itaf_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	// front: classify
	itaf_front #(
		.MAX_FIELD (MAX_FIELD)
	) u_front (
		.value         (value),
		.conv          (conv),
		.size_sel      (size_sel),
		.alt_form      (alt_form),
		.pad_zero      (pad_zero),
		.left_justify  (left_justify),
		.plus_sign     (plus_sign),
		.space_sign    (space_sign),
		.field_width   (field_width),
		.min_precision (min_precision),
		.spec          (spec_in)
	);

	assign item_stall = q_status.full;
	assign push       = item_valid & ~item_stall;

	// queue between front and back
	itaf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (spec_in),
		.pop    (pop),
		.rdata  (spec_out),
		.status (q_status)
	);

	// back: convert and emit
	itaf_back #(
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_rdata    (spec_out),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ch         (ch),
		.last       (last)
	);

endmodule

// File: dv/tb_integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Self-checking testbench for the printf-style integer to ASCII formatter.
// ----------------------------------------------------------------------------
// Every item sent to the block is also run through a local model of the
// conversion. The model queues the characters it expects. A monitor compares
// each character the block hands over with the oldest queued one, on ch and
// on last. Directed tests cover the edge values, each conversion and the flag
// interactions. A random phase then mixes well-formed specs with edge values,
// with random idle cycles on the item side and random stalls on the
// character side.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;

	// flag bits for building directed items: {alt, zero, left, plus, space}
	localparam logic [4:0] F_NONE  = 5'b00000;
	localparam logic [4:0] F_ALT   = 5'b10000;
	localparam logic [4:0] F_ZPAD  = 5'b01000;
	localparam logic [4:0] F_LEFT  = 5'b00100;
	localparam logic [4:0] F_PLUS  = 5'b00010;
	localparam logic [4:0] F_SPACE = 5'b00001;

	localparam int RUN_MAX      = 63;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic signed [63:0]  value;
		itaf_pkg::conv_t     conv;
		itaf_pkg::size_sel_t size_sel;
		logic                alt;
		logic                zpad;
		logic                left;
		logic                plus;
		logic                space;
		logic [5:0]          width;
		logic [5:0]          prec;
	} fmt_item_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_exp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic signed [63:0] value = '0;
	logic [1:0]         conv = '0;
	logic [1:0]         size_sel = '0;
	logic               alt_form = 1'b0;
	logic               pad_zero = 1'b0;
	logic               left_justify = 1'b0;
	logic               plus_sign = 1'b0;
	logic               space_sign = 1'b0;
	logic [5:0]         field_width = '0;
	logic [5:0]         min_precision = '0;
	logic               char_valid;
	logic               char_stall = 1'b0;
	logic [7:0]         ch;
	logic               last;

	char_exp_t pending_chars[$];
	char_exp_t head;
	int        err_count = 0;
	bit        pressure_on = 1'b0;
	int        stall_left = 0;

	integer_to_ascii_formatter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.conv         (conv),
		.size_sel     (size_sel),
		.alt_form     (alt_form),
		.pad_zero     (pad_zero),
		.left_justify (left_justify),
		.plus_sign    (plus_sign),
		.space_sign   (space_sign),
		.field_width  (field_width),
		.min_precision(min_precision),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.ch           (ch),
		.last         (last)
	);

	always #5 clk = ~clk;

	// expected character run for one formatted value
	function automatic void format_run(fmt_item_t it);
		logic [63:0] mask;
		logic [63:0] mag;
		logic [7:0]  pfx[2];
		logic [7:0]  digs[24];
		logic [7:0]  run[$];
		logic [3:0]  nib;
		logic        pfx_done;
		int          pfx_n;
		int          nd;
		int          len;
		int          pz;
		int          pw;
		int          i;
		int          n_out;
		char_exp_t   e;

		pfx_n = 0;
		nd = 0;
		pfx_done = 1'b0;
		case (it.size_sel)
			itaf_pkg::SIZE_CHAR: mask = itaf_pkg::MASK_CHAR;
			itaf_pkg::SIZE_SHORT: mask = itaf_pkg::MASK_SHORT;
			default: mask = itaf_pkg::MASK_NONE;
		endcase
		mag = it.value & mask;

		if (it.conv == itaf_pkg::CONV_SDEC || it.conv == itaf_pkg::CONV_UDEC) begin
			// negative signed values skip the size mask
			if (it.conv == itaf_pkg::CONV_SDEC && it.value[63]) begin
				mag = -it.value;
				pfx[0] = itaf_pkg::CH_MINUS;
				pfx_n = 1;
			end else if (it.plus) begin
				pfx[0] = itaf_pkg::CH_PLUS;
				pfx_n = 1;
			end else if (it.space) begin
				pfx[0] = itaf_pkg::CH_SPACE;
				pfx_n = 1;
			end
			do begin
				digs[nd] = itaf_pkg::CH_ZERO + 8'(mag % 64'd10);
				mag = mag / 64'd10;
				nd++;
			end while (mag != 0);
		end else begin
			if (it.alt && mag != 0) begin
				pfx[0] = itaf_pkg::CH_ZERO;
				pfx[1] = (it.conv == itaf_pkg::CONV_HEXU) ? itaf_pkg::CH_X_UP
					: itaf_pkg::CH_X_LO;
				pfx_n = 2;
			end
			do begin
				nib = mag[3:0];
				if (nib < 4'd10)
					digs[nd] = itaf_pkg::CH_ZERO + 8'(nib);
				else
					digs[nd] = ((it.conv == itaf_pkg::CONV_HEXU) ? itaf_pkg::CH_A_UP
						: itaf_pkg::CH_A_LO) + 8'(nib - 4'd10);
				mag = mag >> 4;
				nd++;
			end while (mag != 0);
		end

		len = nd + pfx_n;
		pz = (int'(it.prec) > len) ? int'(it.prec) - len : 0;
		pw = (int'(it.width) > len + pz) ? int'(it.width) - (len + pz) : 0;

		// left padding; zero padding goes after the prefix
		if (!it.left) begin
			if (it.zpad) begin
				for (i = 0; i < pfx_n; i++) run.push_back(pfx[i]);
				pfx_done = 1'b1;
				for (i = 0; i < pw; i++) run.push_back(itaf_pkg::CH_ZERO);
			end else begin
				for (i = 0; i < pw; i++) run.push_back(itaf_pkg::CH_SPACE);
			end
		end
		if (!pfx_done)
			for (i = 0; i < pfx_n; i++) run.push_back(pfx[i]);
		for (i = 0; i < pz; i++) run.push_back(itaf_pkg::CH_ZERO);
		for (i = nd - 1; i >= 0; i--) run.push_back(digs[i]);
		if (it.left)
			for (i = 0; i < pw; i++) run.push_back(itaf_pkg::CH_SPACE);

		n_out = (run.size() > RUN_MAX) ? RUN_MAX : run.size();
		for (i = 0; i < n_out; i++) begin
			e.ch = run[i];
			e.last = (i == n_out - 1);
			pending_chars.push_back(e);
		end
	endfunction

	function automatic fmt_item_t mk_item(logic [63:0] v, itaf_pkg::conv_t c,
			itaf_pkg::size_sel_t s, logic [4:0] f, int w, int p);
		fmt_item_t it;
		it.value = v;
		it.conv = c;
		it.size_sel = s;
		{it.alt, it.zpad, it.left, it.plus, it.space} = f;
		it.width = 6'(w);
		it.prec = 6'(p);
		return it;
	endfunction

	// idle cycles before an item: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!pressure_on || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 80);
	endfunction

	// send one item; called and returning at a rising edge
	task automatic send_value(fmt_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value <= it.value;
		conv <= it.conv;
		size_sel <= it.size_sel;
		alt_form <= it.alt;
		pad_zero <= it.zpad;
		left_justify <= it.left;
		plus_sign <= it.plus;
		space_sign <= it.space;
		field_width <= it.width;
		min_precision <= it.prec;
		// results cannot come before acceptance, so queue them now
		format_run(it);
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// character side stalls: runs of no stall, short and long stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			char_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!pressure_on || $urandom_range(0, 99) < 70) begin
			char_stall <= 1'b0;
		end else begin
			char_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(10, 60);
		end
	end

	// compare each accepted character with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			if (pending_chars.size() == 0) begin
				$error("ch: no character expected, got %h", ch);
				err_count++;
			end else begin
				head = pending_chars.pop_front();
				if (ch !== head.ch) begin
					$error("ch: expected %h, got %h", head.ch, ch);
					err_count++;
				end
				if (last !== head.last) begin
					$error("last: expected %b, got %b", head.last, last);
					err_count++;
				end
			end
		end
	end

	task automatic test_decimal_values();
		send_value(mk_item(64'd0, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_NONE, 0, 0));
		send_value(mk_item(64'h8000_0000_0000_0000, itaf_pkg::CONV_SDEC,
			itaf_pkg::SIZE_LONG, F_NONE, 0, 0));
		send_value(mk_item(64'h7FFF_FFFF_FFFF_FFFF, itaf_pkg::CONV_SDEC,
			itaf_pkg::SIZE_LONG, F_PLUS, 0, 0));
		// negative signed ignores the char mask
		send_value(mk_item(-64'sd1, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_CHAR,
			F_SPACE, 0, 0));
		send_value(mk_item(64'h1234, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_CHAR,
			F_SPACE, 8, 0));
		send_value(mk_item(-64'sd1, itaf_pkg::CONV_UDEC, itaf_pkg::SIZE_LONG,
			F_PLUS, 0, 0));
		send_value(mk_item(-64'sd1, itaf_pkg::CONV_UDEC, itaf_pkg::SIZE_SHORT,
			F_NONE, 0, 0));
		send_value(mk_item(-64'sd5, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_ZPAD, 10, 0));
		send_value(mk_item(64'd42, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_PLUS | F_SPACE, 0, 5));
	endtask

	task automatic test_hex_forms();
		// no 0x on zero
		send_value(mk_item(64'd0, itaf_pkg::CONV_HEXL, itaf_pkg::SIZE_INT,
			F_ALT, 0, 0));
		send_value(mk_item(64'hDEAD_BEEF_0123_4567, itaf_pkg::CONV_HEXL,
			itaf_pkg::SIZE_LONG, F_ALT, 0, 0));
		// sign flags have no effect on hex
		send_value(mk_item(-64'sd1, itaf_pkg::CONV_HEXU, itaf_pkg::SIZE_LONG,
			F_ALT | F_PLUS | F_SPACE, 0, 0));
		send_value(mk_item(64'hABCD, itaf_pkg::CONV_HEXU, itaf_pkg::SIZE_CHAR,
			F_ALT, 0, 0));
		send_value(mk_item(64'h1F, itaf_pkg::CONV_HEXL, itaf_pkg::SIZE_SHORT,
			F_ALT | F_ZPAD, 8, 0));
		send_value(mk_item(64'h7, itaf_pkg::CONV_HEXL, itaf_pkg::SIZE_INT,
			F_ALT, 0, 6));
	endtask

	task automatic test_padding_rules();
		// left wins over zero padding
		send_value(mk_item(64'd123, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_LEFT | F_ZPAD, 10, 0));
		send_value(mk_item(-64'sd123, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_LEFT, 63, 0));
		send_value(mk_item(64'd7, itaf_pkg::CONV_UDEC, itaf_pkg::SIZE_INT,
			F_NONE, 63, 0));
		send_value(mk_item(64'd7, itaf_pkg::CONV_UDEC, itaf_pkg::SIZE_INT,
			F_ZPAD, 63, 63));
		send_value(mk_item(-64'sd7, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_ZPAD, 63, 0));
		send_value(mk_item(64'd0, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_INT,
			F_NONE, 0, 63));
		send_value(mk_item(64'd99, itaf_pkg::CONV_HEXU, itaf_pkg::SIZE_INT,
			F_ALT | F_LEFT, 20, 10));
		send_value(mk_item(64'd0, itaf_pkg::CONV_UDEC, itaf_pkg::SIZE_CHAR,
			F_SPACE, 5, 3));
		send_value(mk_item(-64'sd1, itaf_pkg::CONV_SDEC, itaf_pkg::SIZE_SHORT,
			5'b11111, 63, 63));
	endtask

	function automatic fmt_item_t rand_item();
		fmt_item_t   it;
		logic [63:0] p;
		logic [31:0] w32;
		int          r;

		case ($urandom_range(0, 5))
			0: it.value = {$urandom, $urandom};
			1: it.value = 64'($urandom_range(0, 20));
			2: begin
				// around powers of ten, where digit counts change
				p = 64'd1;
				repeat ($urandom_range(0, 19)) p = p * 64'd10;
				it.value = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: begin
				w32 = $urandom;
				it.value = $urandom_range(0, 1) ? {{32{w32[31]}}, w32} : {32'd0, w32};
			end
			4: it.value = -64'($urandom_range(1, 1000));
			default: begin
				case ($urandom_range(0, 3))
					0: it.value = 64'h8000_0000_0000_0000;
					1: it.value = 64'h7FFF_FFFF_FFFF_FFFF;
					2: it.value = 64'hFFFF_FFFF_FFFF_FFFF;
					default: it.value = 64'd0;
				endcase
			end
		endcase
		it.conv = itaf_pkg::conv_t'($urandom_range(0, 3));
		it.size_sel = itaf_pkg::size_sel_t'($urandom_range(0, 3));
		{it.alt, it.zpad, it.left, it.plus, it.space} = 5'($urandom);
		r = $urandom_range(0, 99);
		it.width = (r < 70) ? 6'($urandom_range(0, 12)) : (r < 92) ? 6'($urandom) : 6'd63;
		r = $urandom_range(0, 99);
		it.prec = (r < 50) ? 6'd0 : (r < 85) ? 6'($urandom_range(0, 12))
			: (r < 95) ? 6'($urandom) : 6'd63;
		return it;
	endfunction

	// random mix; the middle stretch runs without idling
	task automatic test_random_mix();
		int i;
		pressure_on = 1'b1;
		for (i = 0; i < 150; i++) send_value(rand_item());
		pressure_on = 1'b0;
		for (i = 0; i < 80; i++) send_value(rand_item());
		pressure_on = 1'b1;
		for (i = 0; i < 150; i++) send_value(rand_item());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_decimal_values();
		test_hex_forms();
		test_padding_rules();
		test_random_mix();
		item_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		// watch for stray characters
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// hang guard
	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/itaf_pkg.sv
rtl/core/itaf_front.sv
rtl/core/itaf_queue.sv
rtl/core/itaf_back.sv
rtl/core/integer_to_ascii_formatter.sv
dv/tb_integer_to_ascii_formatter.sv
